// ===== rtl/lpht_pkg.sv =====
// Shared widths, codes and slot type for the linear-probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 3;
    localparam int COUNT_W   = 4;
    localparam int HOME_W    = 3;
    localparam int SLOTS_DEF = 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(2);

    // Result status
    localparam logic [STATUS_W-1:0] RES_OK   = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] RES_MISS = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] RES_FULL = STATUS_W'(2);

    // Slot states
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]       state;
        logic [KEY_W-1:0] key;
    } t_slot;

endpackage

`default_nettype wire

// ===== rtl/lpht_home.sv =====
// Home slot unit: reduces a key modulo 7 by folding base-64 and base-8 digits.
`timescale 1ns / 1ps
`default_nettype none

module lpht_home (
    input  wire logic [lpht_pkg::KEY_W-1:0]  i_key,
    output logic      [lpht_pkg::HOME_W-1:0] o_home
);
    import lpht_pkg::*;

    logic [8:0] sum6;
    logic [6:0] fold1;
    logic [3:0] fold2;
    logic [3:0] fold3;

    // Both 64 and 8 are 1 modulo 7, so digit sums keep the residue.
    always_comb begin
        sum6  = 9'(i_key[5:0]) + 9'(i_key[11:6]) + 9'(i_key[17:12])
              + 9'(i_key[23:18]) + 9'(i_key[29:24]) + 9'(i_key[30]);
        fold1 = 7'(sum6[5:0]) + 7'(sum6[8:6]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]) + 4'(fold1[6]);
        fold3 = 4'(fold2[2:0]) + 4'(fold2[3]);
        o_home = (fold3 >= 4'd7) ? HOME_W'(fold3 - 4'd7) : HOME_W'(fold3);
    end

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the open-addressing hash table with linear probing.
`timescale 1ns / 1ps
`default_nettype none

// Insert, search and delete of 31-bit keys in a table of TABLE_SLOTS slots kept in one
// single-port slot memory. The home slot is key mod 7, and the probe walks one slot per
// cycle, wrapping at the end of the table. An item examines 1 to TABLE_SLOTS slots and
// keeps the block busy until its result is loaded; the result waits in an output register,
// and the next item may be taken while it does. After reset the block sweeps the memory
// to mark every slot empty, one slot per cycle, and holds o_stall high while it does so.
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS = lpht_pkg::SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [lpht_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [lpht_pkg::KEY_W-1:0]      i_key,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [lpht_pkg::STATUS_W-1:0]   o_status,
    output logic      [lpht_pkg::INDEX_W-1:0]    o_slot_index,
    output logic      [lpht_pkg::COUNT_W-1:0]    o_entry_count
);
    import lpht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    t_slot r_mem [TABLE_SLOTS];
    t_slot r_rdata;

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [SLOT_W-1:0]   r_steps, n_steps;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [CMD_W-1:0]    r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [STATUS_W-1:0] r_o_status;
    logic [INDEX_W-1:0]  r_o_index;
    logic [COUNT_W-1:0]  r_o_count;

    logic [HOME_W-1:0]   home;
    logic [SLOT_W-1:0]   next_slot;
    logic                accept;
    logic                out_free;
    logic                key_hit;
    logic                last_step;
    logic                finish;
    logic                load_out;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    logic                wr_en;
    t_slot               wr_data;
    logic [STATUS_W-1:0] res;
    logic                do_place;
    logic                do_remove;

    lpht_home u_home (
        .i_key  (i_key),
        .o_home (home)
    );

    assign accept    = (r_state == S_IDLE) && i_valid;
    assign out_free  = !r_out_valid || !i_stall;
    assign key_hit   = (r_rdata.state == SLOT_USED) && (r_rdata.key == r_key);
    assign last_step = (r_steps == LAST_SLOT);
    assign next_slot = (r_cur == LAST_SLOT) ? '0 : r_cur + 1'b1;

    // Judge the slot whose contents arrived this cycle.
    always_comb begin
        finish    = 1'b0;
        res       = RES_MISS;
        do_place  = 1'b0;
        do_remove = 1'b0;
        unique case (r_cmd) inside
            CMD_INSERT: begin
                if (r_rdata.state != SLOT_USED) begin
                    finish   = 1'b1;
                    res      = RES_OK;
                    do_place = 1'b1;
                end else if (r_rdata.key == r_key) begin
                    finish = 1'b1;
                    res    = RES_OK;
                end else if (last_step) begin
                    finish = 1'b1;
                    res    = RES_FULL;
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                if (r_rdata.state == SLOT_EMPTY) begin
                    finish = 1'b1;
                end else if (key_hit) begin
                    finish    = 1'b1;
                    res       = RES_OK;
                    do_remove = (r_cmd == CMD_DELETE);
                end else if (last_step) begin
                    finish = 1'b1;
                end
            end
            default: begin
                finish = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        load_out    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_cur;
        wr_en       = 1'b0;
        wr_data     = '{state: SLOT_USED, key: r_key};
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '{state: SLOT_EMPTY, key: '0};
                n_cur   = next_slot;
                if (r_cur == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    rd_en   = 1'b1;
                    rd_addr = SLOT_W'(home);
                    n_cur   = SLOT_W'(home);
                    n_steps = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!finish) begin
                    rd_en   = 1'b1;
                    rd_addr = next_slot;
                    n_cur   = next_slot;
                    n_steps = r_steps + 1'b1;
                end else if (out_free) begin
                    // The result register is free: commit the change and report.
                    if (do_place) begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end else if (do_remove) begin
                        wr_en   = 1'b1;
                        wr_data = '{state: SLOT_TOMB, key: r_rdata.key};
                        n_count = r_count - 1'b1;
                    end
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cur   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cur       <= '0;
            r_steps     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_steps     <= n_steps;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
        if (load_out) begin
            r_o_status <= res;
            r_o_index  <= (res == RES_OK) ? INDEX_W'(r_cur) : '0;
            r_o_count  <= COUNT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cur] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_o_status;
    assign o_slot_index  = r_o_index;
    assign o_entry_count = r_o_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SLOTS))
        else $error("occupied count exceeds the table size");

    a_full_means_all_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (res == RES_FULL) |-> r_count == CNT_W'(TABLE_SLOTS))
        else $error("table reported full while a slot is free");

    a_place_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && (r_state == S_PROBE) && (r_cmd == CMD_INSERT)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("new entry did not raise the count");

    a_remove_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && (r_state == S_PROBE) && (r_cmd == CMD_DELETE)
        |=> r_count == $past(r_count) - 1'b1)
        else $error("removal did not lower the count");

    a_probe_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) && last_step |-> finish)
        else $error("probe ran past one full wrap");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_linear_probe_hash_table.sv =====
// Testbench for the linear-probing hash table: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int TBL_SLOTS = SLOTS_DEF;
    localparam int HOME_MOD = 7;
    localparam int POOL_SIZE = 12;
    localparam int RX_HOLD_CYCLES = 80;
    localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot;
        logic [COUNT_W-1:0]  count;
    } t_reply;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [CMD_W-1:0]    i_cmd;
    logic [KEY_W-1:0]    i_key;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [INDEX_W-1:0]  o_slot_index;
    logic [COUNT_W-1:0]  o_entry_count;

    // Shadow copy of the table, updated as each command is accepted.
    logic [KEY_W-1:0] tbl_key [TBL_SLOTS];
    logic [1:0]       tbl_state [TBL_SLOTS];
    int unsigned      tbl_count;

    t_reply           expected_replies[$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               err_count;
    int               tx_idle_pct;
    int               rx_stall_pct;
    bit               rx_hold_req;

    linear_probe_hash_table #(
        .TABLE_SLOTS(TBL_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_entry_count (o_entry_count)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_reply apply_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        t_reply r;
        int     s;
        bit     hit;
        r.status = RES_MISS;
        r.slot = '0;
        hit = 1'b0;
        s = int'(key % HOME_MOD) % TBL_SLOTS;
        case (cmd) inside
            CMD_INSERT: begin
                r.status = RES_FULL;
                for (int n = 0; n < TBL_SLOTS; n++) begin
                    if (tbl_state[s] != SLOT_USED) begin
                        tbl_key[s] = key;
                        tbl_state[s] = SLOT_USED;
                        tbl_count++;
                        hit = 1'b1;
                        break;
                    end
                    if (tbl_key[s] == key) begin
                        hit = 1'b1;
                        break;
                    end
                    s = (s + 1) % TBL_SLOTS;
                end
            end
            CMD_SEARCH, CMD_DELETE: begin
                for (int n = 0; n < TBL_SLOTS; n++) begin
                    if (tbl_state[s] == SLOT_EMPTY) begin
                        break;
                    end
                    if (tbl_state[s] == SLOT_USED && tbl_key[s] == key) begin
                        hit = 1'b1;
                        break;
                    end
                    s = (s + 1) % TBL_SLOTS;
                end
                if (hit && cmd == CMD_DELETE) begin
                    tbl_state[s] = SLOT_TOMB;
                    if (tbl_count > 0) begin
                        tbl_count--;
                    end
                end
            end
            default: ;
        endcase
        if (hit) begin
            r.status = RES_OK;
            r.slot = INDEX_W'(s);
        end
        r.count = COUNT_W'(tbl_count);
        return r;
    endfunction

    // Offer one command and hold it until the block takes the transfer.
    task automatic issue_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        int     gap;
        t_reply reply;
        gap = pick_gap(tx_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_key <= key;
        do @(posedge i_clk); while (o_stall);
        reply = apply_command(cmd, key);
        expected_replies = {expected_replies, reply};
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic refresh_key_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = ($urandom_range(1) == 0) ? KEY_W'($urandom_range(0, 48))
                                                   : KEY_W'($urandom);
        end
    endtask

    task automatic run_random(int count, int ins_pct, int del_pct);
        int               roll;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        refresh_key_pool();
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                cmd = CMD_UNUSED;
            end else if (roll < ins_pct) begin
                cmd = CMD_INSERT;
            end else if (roll < ins_pct + del_pct) begin
                cmd = CMD_DELETE;
            end else begin
                cmd = CMD_SEARCH;
            end
            if ($urandom_range(19) == 0) begin
                key = KEY_W'($urandom);
            end else begin
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            end
            if ($urandom_range(19) == 0) begin
                key_pool[$urandom_range(POOL_SIZE - 1)] = KEY_W'($urandom);
            end
            issue_command(cmd, key);
        end
    endtask

    // Collisions on home slots 0, 1 and 6, wrap-around, tombstones, a full table and misses.
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        issue_command(CMD_SEARCH, '0);
        issue_command(CMD_DELETE, KEY_W'(5));
        issue_command(CMD_INSERT, '0);
        issue_command(CMD_INSERT, KEY_W'(7));
        issue_command(CMD_INSERT, '0);
        issue_command(CMD_INSERT, KEY_MAX);
        issue_command(CMD_INSERT, KEY_W'(6));
        issue_command(CMD_INSERT, KEY_W'(13));
        issue_command(CMD_INSERT, KEY_W'(20));
        issue_command(CMD_SEARCH, KEY_W'(20));
        issue_command(CMD_DELETE, KEY_W'(7));
        issue_command(CMD_SEARCH, KEY_MAX);
        issue_command(CMD_SEARCH, KEY_W'(7));
        issue_command(CMD_INSERT, KEY_W'(14));
        issue_command(CMD_INSERT, KEY_W'(4));
        issue_command(CMD_INSERT, KEY_W'(5));
        issue_command(CMD_INSERT, KEY_W'(3));
        issue_command(CMD_SEARCH, KEY_W'(3));
        issue_command(CMD_DELETE, KEY_W'(3));
        issue_command(CMD_UNUSED, KEY_MAX);
        issue_command(CMD_DELETE, KEY_W'(4));
        issue_command(CMD_SEARCH, KEY_W'(11));
        issue_command(CMD_INSERT, KEY_W'(11));
        issue_command(CMD_DELETE, KEY_MAX);
        wait_for_drain();
    endtask

    task automatic test_random_steady();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random(180, 44, 25);
    endtask

    task automatic test_random_idle();
        tx_idle_pct = 30;
        rx_stall_pct = 30;
        run_random(180, 44, 25);
    endtask

    // The receiver stalls for a long stretch while commands keep coming back to back.
    task automatic test_receiver_holdoff();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 1'b1;
        run_random(40, 50, 20);
        wait_for_drain();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct = 20;
        rx_stall_pct = 20;
        for (int b = 0; b < 3; b++) begin
            run_random(8, 50, 25);
            wait_for_drain();
        end
    endtask

    task automatic test_random_delete_heavy();
        tx_idle_pct = 15;
        rx_stall_pct = 15;
        run_random(180, 25, 50);
    endtask

    task automatic test_random_insert_heavy();
        tx_idle_pct = 15;
        rx_stall_pct = 40;
        run_random(180, 70, 10);
    endtask

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = RX_HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(rx_stall_pct);
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_reply exp_reply;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_replies.size() == 0) begin
                $error("result transfer with no command outstanding");
                err_count++;
            end else begin
                exp_reply = expected_replies.pop_front();
                if (o_status !== exp_reply.status) begin
                    $error("o_status: expected %0d, got %0d", exp_reply.status, o_status);
                    err_count++;
                end
                if (o_slot_index !== exp_reply.slot) begin
                    $error("o_slot_index: expected %0d, got %0d", exp_reply.slot, o_slot_index);
                    err_count++;
                end
                if (o_entry_count !== exp_reply.count) begin
                    $error("o_entry_count: expected %0d, got %0d",
                           exp_reply.count, o_entry_count);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #1_500_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        err_count = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 1'b0;
        tbl_count = 0;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            tbl_key[i] = '0;
            tbl_state[i] = SLOT_EMPTY;
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_INSERT;
        i_key = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_steady();
        test_random_idle();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_delete_heavy();
        test_random_insert_heavy();

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
